>>> hdl/eavg_pkg.sv
// Shared constants, types and functions of the ellipse arc vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package eavg_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    // Magnitude of angle_span * point_index needs 33 bits.
    localparam int DIV_BITS   = 33;
    localparam int SEG_BITS   = 16;
    localparam int STAGE_BITS = 5;

    // Product, magnitude, divider cells, angle, CORDIC setup, CORDIC cells,
    // radius scaling, rounding, rotation products, rotation sum, output.
    localparam int LATENCY = DIV_BITS + CORDIC_STAGES + 9;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X      = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y      = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X      = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y      = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION      = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_PHASE   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_SPAN    = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEGMENT_COUNT = 4'd7;

    localparam logic [30:0]        RADIUS_RESET  = 31'(64'd1 << FRAC_BITS);
    localparam logic signed [17:0] SPAN_RESET    = 18'(64'd1 << ANGLE_BITS);
    localparam logic [15:0]        SEGMENT_RESET = 16'd32;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [63:0] HALF_Q30    = 64'sd536870912;

    typedef logic [ANGLE_BITS-1:0] t_angle;

    typedef struct packed {
        logic [SEG_BITS-1:0] rem;
        logic [DIV_BITS-1:0] num;
        t_angle              quo;
        logic                neg;
    } t_div;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } t_cordic;

    // atan(2^-k) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn32(input logic [STAGE_BITS-1:0] k);
        case (k)
            5'd0:    return 32'h20000000;
            5'd1:    return 32'h12E4051D;
            5'd2:    return 32'h09FB385B;
            5'd3:    return 32'h051111D4;
            5'd4:    return 32'h028B0D43;
            5'd5:    return 32'h0145D7E1;
            5'd6:    return 32'h00A2F61E;
            5'd7:    return 32'h00517C55;
            5'd8:    return 32'h0028BE53;
            5'd9:    return 32'h00145F2E;
            5'd10:   return 32'h000A2F98;
            5'd11:   return 32'h000517CC;
            5'd12:   return 32'h00028BE6;
            5'd13:   return 32'h000145F3;
            5'd14:   return 32'h0000A2F9;
            5'd15:   return 32'h0000517C;
            5'd16:   return 32'h000028BE;
            5'd17:   return 32'h0000145F;
            5'd18:   return 32'h00000A2F;
            5'd19:   return 32'h00000517;
            5'd20:   return 32'h0000028B;
            5'd21:   return 32'h00000145;
            5'd22:   return 32'h000000A2;
            5'd23:   return 32'h00000051;
            default: return 32'h00000000;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Splits the angle into the nearest quarter turn and a residual.
    function automatic t_cordic cordic_prep(input t_angle a);
        logic [31:0] a32;
        logic [31:0] sum;
        t_cordic     c;
        a32    = 32'(a) << (32 - ANGLE_BITS);
        sum    = a32 + 32'h20000000;
        c.quad = sum[31:30];
        c.z    = $signed(a32 - {c.quad, 30'd0});
        c.x    = CORDIC_GAIN;
        c.y    = 32'sd0;
        return c;
    endfunction

    function automatic logic signed [31:0] cos_of(input t_cordic c);
        case (c.quad)
            2'd0:    return c.x;
            2'd1:    return -c.y;
            2'd2:    return -c.x;
            default: return c.y;
        endcase
    endfunction

    function automatic logic signed [31:0] sin_of(input t_cordic c);
        case (c.quad)
            2'd0:    return c.y;
            2'd1:    return c.x;
            2'd2:    return -c.y;
            default: return -c.x;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> hdl/ellipse_arc_vertex_generator_unit.sv
// Top level of the ellipse arc vertex generator: config, cell chains, output math.
// A vertex reaches the result ports after every stage that LATENCY sums up.
// Throughput: one transaction per clock; busy stays low, start may be held high.
// The divider (33 cells) and CORDIC chains (16 cells each) dominate the latency.
// Reset (synchronous, active low) clears the valid pipeline and loads the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module ellipse_arc_vertex_generator_unit import eavg_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [15:0]              i_point_index,
    input  wire logic                     i_emit_center,
    output logic                          o_valid,
    output logic signed [31:0]            o_vertex_x,
    output logic signed [31:0]            o_vertex_y,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Config registers; the user must change them only while no transaction is
    // in flight, which the block does not enforce. Stages read them, not copies.
    logic signed [31:0] r_center_x;
    logic signed [31:0] r_center_y;
    logic [30:0]        r_radius_x;
    logic [30:0]        r_radius_y;
    logic [15:0]        r_rotation;
    logic [15:0]        r_start_phase;
    logic signed [17:0] r_angle_span;
    logic [15:0]        r_segment_count;

    logic               accept;
    logic [SEG_BITS-1:0] w_seg;

    // Control pipeline: valid and centre-request flags ride alongside the data.
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-2:0] r_ctr;

    logic signed [33:0]  r_prod;
    logic [DIV_BITS-1:0] r_mag;
    logic                r_neg;
    t_angle              r_angle;
    t_angle              w_quo;

    t_div    w_div   [0:DIV_BITS];
    t_cordic w_cor_t [0:CORDIC_STAGES];
    t_cordic w_cor_r [0:CORDIC_STAGES];
    t_cordic r_prep_t;
    t_cordic r_prep_r;

    logic signed [63:0] r_px;
    logic signed [63:0] r_py;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_sr;
    logic signed [31:0] r_cr_d;
    logic signed [31:0] r_sr_d;
    logic signed [31:0] r_xl;
    logic signed [31:0] r_yl;
    logic signed [63:0] r_pa;
    logic signed [63:0] r_pb;
    logic signed [63:0] r_pc;
    logic signed [63:0] r_pd;
    logic signed [33:0] r_rot_x;
    logic signed [33:0] r_rot_y;
    logic signed [31:0] r_vertex_x;
    logic signed [31:0] r_vertex_y;

    logic signed [63:0] w_rnd_x;
    logic signed [63:0] w_rnd_y;
    logic signed [63:0] w_sum_x;
    logic signed [63:0] w_sum_y;
    logic signed [34:0] w_out_x;
    logic signed [34:0] w_out_y;

    // The pipeline never stalls, so a new transaction is taken every cycle.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // A segment count of zero divides as one.
    assign w_seg = (r_segment_count == 16'd0) ? 16'd1 : r_segment_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= 32'sd0;
            r_center_y      <= 32'sd0;
            r_radius_x      <= RADIUS_RESET;
            r_radius_y      <= RADIUS_RESET;
            r_rotation      <= 16'd0;
            r_start_phase   <= 16'd0;
            r_angle_span    <= SPAN_RESET;
            r_segment_count <= SEGMENT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CENTER_X:      r_center_x      <= $signed(i_cfg_data);
                REG_CENTER_Y:      r_center_y      <= $signed(i_cfg_data);
                REG_RADIUS_X:      r_radius_x      <= i_cfg_data[30:0];
                REG_RADIUS_Y:      r_radius_y      <= i_cfg_data[30:0];
                REG_ROTATION:      r_rotation      <= i_cfg_data[15:0];
                REG_START_PHASE:   r_start_phase   <= i_cfg_data[15:0];
                REG_ANGLE_SPAN:    r_angle_span    <= $signed(i_cfg_data[17:0]);
                REG_SEGMENT_COUNT: r_segment_count <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ctr <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], accept};
            r_ctr <= {r_ctr[LATENCY-3:0], accept && i_emit_center};
        end
    end

    // Arc parameter: span times index, then its magnitude and sign for the
    // divider, since the quotient truncates toward zero.
    always_ff @(posedge i_clk) begin
        r_prod <= 34'(r_angle_span) * $signed({18'd0, i_point_index});
        r_neg  <= r_prod[33];
        r_mag  <= r_prod[33] ? DIV_BITS'(-r_prod) : DIV_BITS'(r_prod);
    end

    assign w_div[0] = '{rem: '0, num: r_mag, quo: '0, neg: r_neg};

    // Divider chain: each cell resolves one quotient bit, most significant
    // first. Only the low quotient bits matter because the angle wraps.
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        eavg_div_cell u_cell (
            .i_clk (i_clk),
            .i_seg (w_seg),
            .i_d   (w_div[k]),
            .o_d   (w_div[k+1])
        );
    end

    assign w_quo = w_div[DIV_BITS].neg ? t_angle'(-w_div[DIV_BITS].quo)
                                       : w_div[DIV_BITS].quo;

    always_ff @(posedge i_clk) begin
        r_angle  <= t_angle'(r_start_phase) + w_quo;
        r_prep_t <= cordic_prep(r_angle);
        r_prep_r <= cordic_prep(t_angle'(r_rotation));
    end

    assign w_cor_t[0] = r_prep_t;
    assign w_cor_r[0] = r_prep_r;

    // Two CORDIC chains run side by side: one for the arc angle and one for
    // the rotation angle of the ellipse.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        eavg_cordic_cell u_arc (
            .i_clk   (i_clk),
            .i_stage (STAGE_BITS'(k)),
            .i_d     (w_cor_t[k]),
            .o_d     (w_cor_t[k+1])
        );
        eavg_cordic_cell u_rot (
            .i_clk   (i_clk),
            .i_stage (STAGE_BITS'(k)),
            .i_d     (w_cor_r[k]),
            .o_d     (w_cor_r[k+1])
        );
    end

    // Round the radius-scaled point and the rotation sums half up, add the centre.
    always_comb begin
        w_rnd_x = r_px + HALF_Q30;
        w_rnd_y = r_py + HALF_Q30;
        w_sum_x = r_pa - r_pb + HALF_Q30;
        w_sum_y = r_pc + r_pd + HALF_Q30;
        w_out_x = 35'(r_center_x) + 35'(r_rot_x);
        w_out_y = 35'(r_center_y) + 35'(r_rot_y);
    end

    always_ff @(posedge i_clk) begin
        r_px    <= $signed({1'b0, r_radius_x}) * cos_of(w_cor_t[CORDIC_STAGES]);
        r_py    <= $signed({1'b0, r_radius_y}) * sin_of(w_cor_t[CORDIC_STAGES]);
        r_cr    <= cos_of(w_cor_r[CORDIC_STAGES]);
        r_sr    <= sin_of(w_cor_r[CORDIC_STAGES]);

        // The rounded product keeps its sign when widened for saturation.
        r_xl    <= sat32(35'($signed(w_rnd_x[63:30])));
        r_yl    <= sat32(35'($signed(w_rnd_y[63:30])));
        r_cr_d  <= r_cr;
        r_sr_d  <= r_sr;

        // Rotate the local point by the ellipse rotation.
        r_pa    <= r_xl * r_cr_d;
        r_pb    <= r_yl * r_sr_d;
        r_pc    <= r_xl * r_sr_d;
        r_pd    <= r_yl * r_cr_d;

        r_rot_x <= w_sum_x[63:30];
        r_rot_y <= w_sum_y[63:30];

        // A centre request returns the centre unchanged.
        if (r_ctr[LATENCY-2]) begin
            r_vertex_x <= r_center_x;
            r_vertex_y <= r_center_y;
        end else begin
            r_vertex_x <= sat32(w_out_x);
            r_vertex_y <= sat32(w_out_y);
        end
    end

    assign o_valid    = r_vld[LATENCY-1];
    assign o_vertex_x = r_vertex_x;
    assign o_vertex_y = r_vertex_y;

endmodule
`default_nettype wire

>>> hdl/eavg_div_cell.sv
// One restoring division cell: settles one quotient bit per clock.
`timescale 1ns / 1ps
`default_nettype none
module eavg_div_cell import eavg_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic [SEG_BITS-1:0] i_seg,
    input  wire t_div                i_d,
    output t_div                     o_d
);

    logic [SEG_BITS:0] trial;
    logic              qbit;
    t_div              n_d;
    t_div              r_d;

    always_comb begin
        trial   = {i_d.rem, i_d.num[DIV_BITS-1]};
        qbit    = (trial >= {1'b0, i_seg});
        n_d.num = i_d.num << 1;
        n_d.quo = {i_d.quo[ANGLE_BITS-2:0], qbit};
        n_d.neg = i_d.neg;
        if (qbit) begin
            n_d.rem = SEG_BITS'(trial - {1'b0, i_seg});
        end else begin
            n_d.rem = trial[SEG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

>>> hdl/eavg_cordic_cell.sv
// One CORDIC rotation cell: a shift-add micro-rotation per clock.
`timescale 1ns / 1ps
`default_nettype none
module eavg_cordic_cell import eavg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic [STAGE_BITS-1:0] i_stage,
    input  wire t_cordic               i_d,
    output t_cordic                    o_d
);

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] step;
    t_cordic            n_d;
    t_cordic            r_d;

    always_comb begin
        dx       = $signed(i_d.y) >>> i_stage;
        dy       = $signed(i_d.x) >>> i_stage;
        step     = $signed(atan_turn32(i_stage));
        n_d.quad = i_d.quad;
        if (!i_d.z[31]) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - step;
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_d = r_d;

endmodule
`default_nettype wire

>>> hdl/eavg_checker.sv
// Port-level checker of the ellipse arc vertex generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module eavg_checker import eavg_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic [15:0]              i_point_index,
    input wire logic                     i_emit_center,
    input wire logic                     o_valid,
    input wire logic signed [31:0]       o_vertex_x,
    input wire logic signed [31:0]       o_vertex_y,
    input wire logic                     i_cfg_valid,
    input wire logic                     o_cfg_ready,
    input wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [LATENCY-1:0] r_sh;
    logic [LATENCY-1:0] r_csh;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic [30:0]        r_rx;
    logic [30:0]        r_ry;
    logic               wr;

    assign wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh  <= '0;
            r_csh <= '0;
            r_cx  <= 32'sd0;
            r_cy  <= 32'sd0;
            r_rx  <= RADIUS_RESET;
            r_ry  <= RADIUS_RESET;
        end else begin
            r_sh  <= {r_sh[LATENCY-2:0], start && !busy};
            r_csh <= {r_csh[LATENCY-2:0], start && !busy && i_emit_center};
            if (wr && i_cfg_index == REG_CENTER_X) begin
                r_cx <= $signed(i_cfg_data);
            end
            if (wr && i_cfg_index == REG_CENTER_Y) begin
                r_cy <= $signed(i_cfg_data);
            end
            if (wr && i_cfg_index == REG_RADIUS_X) begin
                r_rx <= i_cfg_data[30:0];
            end
            if (wr && i_cfg_index == REG_RADIUS_Y) begin
                r_ry <= i_cfg_data[30:0];
            end
        end
    end

    // Each accepted transaction yields exactly one result, a fixed time later.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == r_sh[LATENCY-1])
        else $error("result strobe does not match accepted transactions");

    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_csh[LATENCY-1] |-> o_vertex_x == r_cx && o_vertex_y == r_cy)
        else $error("centre request did not return the centre");

    // With both radii zero every perimeter point collapses onto the centre.
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_csh[LATENCY-1] && r_rx == 31'd0 && r_ry == 31'd0
        |-> o_vertex_x == r_cx && o_vertex_y == r_cy)
        else $error("zero-radius point differs from the centre");

endmodule

bind ellipse_arc_vertex_generator_unit eavg_checker u_eavg_checker (.*);
`default_nettype wire
